// File: rtl/core/yrag_pkg.sv
// yrag_pkg: shared types and constants of the yuv420 clip rectangle address generator
`default_nettype none
package yrag_pkg;

	localparam int FRAC_BITS = 11;

	// register indexes of the configuration port
	localparam logic [2:0] REG_FRAME_BASE  = 3'd0;
	localparam logic [2:0] REG_FORMAT      = 3'd1;
	localparam logic [2:0] REG_FRAME_W     = 3'd2;
	localparam logic [2:0] REG_FRAME_H     = 3'd3;
	localparam logic [2:0] REG_DEST_BASE   = 3'd4;
	localparam logic [2:0] REG_DEST_PITCH  = 3'd5;
	localparam logic [2:0] REG_SCALE_X     = 3'd6;
	localparam logic [2:0] REG_SCALE_Y     = 3'd7;

	// format codes
	localparam logic [1:0] FMT_YV12 = 2'd0;
	localparam logic [1:0] FMT_I420 = 2'd1;

	localparam logic [15:0] SCALE_ONE = 16'd2048;

	typedef struct packed {
		logic [31:0] frame_base_addr;
		logic [1:0]  format_mode;
		logic [11:0] src_width;
		logic [11:0] src_height;
		logic [31:0] dest_base_addr;
		logic [14:0] dest_pitch;
		logic [15:0] scale_x;
		logic [15:0] scale_y;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] rect_left;
		logic signed [15:0] rect_top;
		logic signed [15:0] rect_right;
		logic signed [15:0] rect_bottom;
		logic signed [15:0] box_left;
		logic signed [15:0] box_top;
	} in_word_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] y_address;
		logic [31:0] u_address;
		logic [31:0] v_address;
		logic [31:0] dest_address;
		logic [31:0] crop_width;
		logic [31:0] crop_height;
		logic [15:0] out_width;
		logic [15:0] out_height;
	} out_word_t;

	// after the difference stage
	typedef struct packed {
		logic [15:0] w;
		logic [15:0] h;
		logic [15:0] dx;
		logic [15:0] dy;
		logic [15:0] rl;
		logic [15:0] rt;
	} s1_t;

	// after the scaling stage
	typedef struct packed {
		logic [15:0] w;
		logic [15:0] h;
		logic [20:0] cw;
		logic [20:0] ch;
		logic [15:0] sx;
		logic [15:0] sy;
		logic [31:0] dest_part;
		logic [31:0] dest_row;
	} s2_t;

	// after the plane product stage
	typedef struct packed {
		logic [15:0] w;
		logic [15:0] h;
		logic [20:0] cw;
		logic [20:0] ch;
		logic [15:0] sx;
		logic [27:0] sy_fw;
		logic [25:0] row;
		logic [23:0] luma;
		logic [31:0] dest_address;
	} s3_t;

endpackage
`default_nettype wire

// File: rtl/core/yrag_diff.sv
// yrag_diff: first stage, absolute coordinate differences
`default_nettype none
module yrag_diff (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid,
	input  wire yrag_pkg::in_word_t word,
	output logic                 valid_s1,
	output yrag_pkg::s1_t        data_s1
);
	import yrag_pkg::*;

	function automatic logic [15:0] absdiff(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] d;
		logic [16:0] n;
		d = {a[15], a} - {b[15], b};
		n = 17'd0 - d;
		return d[16] ? n[15:0] : d[15:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (valid) begin
			data_s1.w  <= absdiff(word.rect_right, word.rect_left);
			data_s1.h  <= absdiff(word.rect_bottom, word.rect_top);
			data_s1.dx <= absdiff(word.rect_left, word.box_left);
			data_s1.dy <= absdiff(word.rect_top, word.box_top);
			data_s1.rl <= word.rect_left;
			data_s1.rt <= word.rect_top;
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/yrag_scale.sv
// yrag_scale: second stage, 5.11 scaling and destination row product
`default_nettype none
module yrag_scale (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire yrag_pkg::cfg_t cfg,
	input  wire logic          valid_s1,
	input  wire yrag_pkg::s1_t data_s1,
	output logic               valid_s2,
	output yrag_pkg::s2_t      data_s2
);
	import yrag_pkg::*;

	logic [31:0] pw;
	logic [31:0] ph;
	logic [31:0] px;
	logic [31:0] py;
	logic [31:0] prow;
	logic [31:0] rl2;

	assign pw   = data_s1.w  * cfg.scale_x;
	assign ph   = data_s1.h  * cfg.scale_y;
	assign px   = data_s1.dx * cfg.scale_x;
	assign py   = data_s1.dy * cfg.scale_y;
	// signed top times unsigned pitch, low 32 bits
	assign prow = {{16{data_s1.rt[15]}}, data_s1.rt} * {17'd0, cfg.dest_pitch};
	assign rl2  = {{15{data_s1.rl[15]}}, data_s1.rl, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			data_s2.w         <= data_s1.w;
			data_s2.h         <= data_s1.h;
			data_s2.cw        <= pw[31:FRAC_BITS];
			data_s2.ch        <= ph[31:FRAC_BITS];
			data_s2.sx        <= px[FRAC_BITS+15:FRAC_BITS];
			data_s2.sy        <= py[FRAC_BITS+15:FRAC_BITS];
			data_s2.dest_part <= cfg.dest_base_addr + rl2;
			data_s2.dest_row  <= prow;
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/yrag_plane.sv
// yrag_plane: third stage, plane products and destination address
`default_nettype none
module yrag_plane (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire yrag_pkg::cfg_t cfg,
	input  wire logic          valid_s2,
	input  wire yrag_pkg::s2_t data_s2,
	output logic               valid_s3,
	output yrag_pkg::s3_t      data_s3
);
	import yrag_pkg::*;

	logic [11:0] row_pitch;
	logic [26:0] row_prod;
	logic [25:0] row;

	// yv12 halves the pitch first, i420 halves the product
	assign row_pitch = (cfg.format_mode == FMT_YV12) ? {1'b0, cfg.src_width[11:1]}
		: cfg.src_width;
	assign row_prod  = data_s2.sy[15:1] * row_pitch;
	assign row       = (cfg.format_mode == FMT_YV12) ? row_prod[25:0] : row_prod[26:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			data_s3.w            <= data_s2.w;
			data_s3.h            <= data_s2.h;
			data_s3.cw           <= data_s2.cw;
			data_s3.ch           <= data_s2.ch;
			data_s3.sx           <= data_s2.sx;
			data_s3.sy_fw        <= data_s2.sy * cfg.src_width;
			data_s3.row          <= row;
			data_s3.luma         <= cfg.src_width * cfg.src_height;
			data_s3.dest_address <= data_s2.dest_part + data_s2.dest_row;
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/yuv420_clip_rect_address_gen_unit.sv
// yuv420_clip_rect_address_gen_unit: top level of the clip rectangle address generator
`default_nettype none
// usage
//   configuration: wr_en, wr_index and wr_data write one register per clock; write only
//   while no rectangle is in flight (until done has come back for the last start)
//   input: one rectangle word on rect_word is taken at each clock where start is high;
//   busy is always low, so a rectangle may be issued every clock
//   output: done is high for one clock with the result word on result; the receiver
//   cannot hold it off, so the pipeline never stalls
//   stages: a rectangle taken at an edge passes four register stages (differences,
//   5.11 scaling, plane products, final adds) before it is on result
//   throughput: one rectangle per clock, set by the fully pipelined multipliers
//   reset: arst_n clears the stage valid bits and done, and returns the registers to
//   their reset values (scale factors 1.0, everything else zero)
//   unsupported format: ok low and the plane addresses zero, other fields as usual
module yuv420_clip_rect_address_gen_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire logic [2:0]         wr_index,
	input  wire logic [31:0]        wr_data,
	input  wire logic               start,
	output logic                    busy,
	input  wire yrag_pkg::in_word_t rect_word,
	output logic                    done,
	output yrag_pkg::out_word_t     result
);
	import yrag_pkg::*;

	cfg_t      cfg_q;
	logic      valid_s1;
	logic      valid_s2;
	logic      valid_s3;
	s1_t       data_s1;
	s2_t       data_s2;
	s3_t       data_s3;
	logic      done_q;
	out_word_t result_q;

	logic        fmt_ok;
	logic [31:0] plane_base;
	logic [31:0] near_plane;
	logic [31:0] far_plane;
	logic [31:0] y_addr;
	logic [26:0] chroma_off;

	// the pipeline never stalls, so a rectangle is taken whenever start is high
	assign busy = 1'b0;

	// configuration registers, values masked to their widths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_base_addr <= 32'd0;
			cfg_q.format_mode     <= FMT_YV12;
			cfg_q.src_width       <= 12'd0;
			cfg_q.src_height      <= 12'd0;
			cfg_q.dest_base_addr  <= 32'd0;
			cfg_q.dest_pitch      <= 15'd0;
			cfg_q.scale_x         <= SCALE_ONE;
			cfg_q.scale_y         <= SCALE_ONE;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FRAME_BASE: cfg_q.frame_base_addr <= wr_data;
				REG_FORMAT:     cfg_q.format_mode     <= wr_data[1:0];
				REG_FRAME_W:    cfg_q.src_width       <= wr_data[11:0];
				REG_FRAME_H:    cfg_q.src_height      <= wr_data[11:0];
				REG_DEST_BASE:  cfg_q.dest_base_addr  <= wr_data;
				REG_DEST_PITCH: cfg_q.dest_pitch      <= wr_data[14:0];
				REG_SCALE_X:    cfg_q.scale_x         <= wr_data[15:0];
				REG_SCALE_Y:    cfg_q.scale_y         <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	yrag_diff u_diff (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (start),
		.word     (rect_word),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	yrag_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	yrag_plane u_plane (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3)
	);

	// final stage: plane address sums
	assign fmt_ok     = (cfg_q.format_mode == FMT_YV12) || (cfg_q.format_mode == FMT_I420);
	assign chroma_off = {12'd0, data_s3.sx[15:1]} + {1'b0, data_s3.row};
	assign plane_base = cfg_q.frame_base_addr + {8'd0, data_s3.luma};
	// first chroma plane right after luma, second one a quarter frame later
	assign near_plane = plane_base + {5'd0, chroma_off};
	assign far_plane  = near_plane + {10'd0, data_s3.luma[23:2]};
	assign y_addr     = cfg_q.frame_base_addr + {16'd0, data_s3.sx} + {4'd0, data_s3.sy_fw};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			result_q.ok           <= fmt_ok;
			result_q.y_address    <= fmt_ok ? y_addr : 32'd0;
			// yv12 holds v first, i420 holds u first
			result_q.u_address    <= !fmt_ok ? 32'd0
				: (cfg_q.format_mode == FMT_I420) ? near_plane : far_plane;
			result_q.v_address    <= !fmt_ok ? 32'd0
				: (cfg_q.format_mode == FMT_I420) ? far_plane : near_plane;
			result_q.dest_address <= data_s3.dest_address;
			result_q.crop_width   <= {11'd0, data_s3.cw};
			result_q.crop_height  <= {11'd0, data_s3.ch};
			result_q.out_width    <= data_s3.w;
			result_q.out_height   <= data_s3.h;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// every word that is taken comes back with done high
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##3 done)
		else $error("result word missing after accepted rectangle");

	// unsupported format gives zero plane addresses
	a_zero_planes: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.ok) |->
		(result.y_address == 32'd0 && result.u_address == 32'd0
		 && result.v_address == 32'd0))
		else $error("plane address nonzero for unsupported format");

	// an empty rectangle scales to an empty crop
	a_empty_crop: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.out_width == 16'd0) |-> (result.crop_width == 32'd0))
		else $error("crop width nonzero for zero width rectangle");

endmodule
`default_nettype wire

// File: bench/tb_yuv420_clip_rect_address_gen_unit.sv
// self-checking bench of the yuv420 clip rectangle address generator, with a word scoreboard
`timescale 1ns / 100ps
module tb_yuv420_clip_rect_address_gen_unit;
	import yrag_pkg::*;

	// the two format codes the block does not support
	localparam logic [1:0] FMT_SPARE_2 = 2'd2;
	localparam logic [1:0] FMT_SPARE_3 = 2'd3;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int DIRECTED_NUM = 8;

	// keeps its own copy of the registers and the queue of expected result words
	class rect_addr_scoreboard;
		cfg_t      regs;
		out_word_t expected_words[$];
		int        mismatches;

		function new();
			regs            = '0;
			regs.scale_x    = SCALE_ONE;
			regs.scale_y    = SCALE_ONE;
			mismatches      = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_FRAME_BASE: regs.frame_base_addr = data;
				REG_FORMAT:     regs.format_mode     = data[1:0];
				REG_FRAME_W:    regs.src_width       = data[11:0];
				REG_FRAME_H:    regs.src_height      = data[11:0];
				REG_DEST_BASE:  regs.dest_base_addr  = data;
				REG_DEST_PITCH: regs.dest_pitch      = data[14:0];
				REG_SCALE_X:    regs.scale_x         = data[15:0];
				REG_SCALE_Y:    regs.scale_y         = data[15:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] abs_diff(int a, int b);
			int d;
			d = a - b;
			return (d < 0) ? -d : d;
		endfunction

		// unsigned 5.11 scaling, 64-bit product then drop the fraction
		function logic [31:0] scale_len(logic [31:0] len, logic [15:0] factor);
			logic [63:0] prod;
			prod = {32'd0, len} * {48'd0, factor};
			return 32'(prod >> FRAC_BITS);
		endfunction

		function out_word_t predict_addresses(in_word_t w);
			out_word_t   r;
			int          rl, rt, rr, rb, bl, bt;
			logic [31:0] wd, ht, sx, sy, fw, fh, luma, quarter, off, base, rl_u, rt_u;
			rl   = w.rect_left;
			rt   = w.rect_top;
			rr   = w.rect_right;
			rb   = w.rect_bottom;
			bl   = w.box_left;
			bt   = w.box_top;
			rl_u = rl;
			rt_u = rt;
			fw   = {20'd0, regs.src_width};
			fh   = {20'd0, regs.src_height};
			base = regs.frame_base_addr;
			wd   = abs_diff(rr, rl);
			ht   = abs_diff(rb, rt);
			r    = '0;
			r.out_width    = wd[15:0];
			r.out_height   = ht[15:0];
			r.crop_width   = scale_len(wd, regs.scale_x);
			r.crop_height  = scale_len(ht, regs.scale_y);
			r.dest_address = regs.dest_base_addr + rl_u * 32'd2 + rt_u * {17'd0, regs.dest_pitch};
			// crop origin keeps only 16 bits
			sx      = scale_len(abs_diff(rl, bl), regs.scale_x) & 32'h0000_FFFF;
			sy      = scale_len(abs_diff(rt, bt), regs.scale_y) & 32'h0000_FFFF;
			luma    = fw * fh;
			quarter = luma >> 2;
			case (regs.format_mode)
				FMT_YV12: begin
					off         = (sx >> 1) + (sy >> 1) * (fw >> 1);
					r.ok        = 1'b1;
					r.y_address = base + sx + sy * fw;
					r.v_address = base + luma + off;
					r.u_address = base + luma + quarter + off;
				end
				FMT_I420: begin
					off         = (sx >> 1) + (((sy >> 1) * fw) >> 1);
					r.ok        = 1'b1;
					r.y_address = base + sx + sy * fw;
					r.u_address = base + luma + off;
					r.v_address = base + luma + quarter + off;
				end
				default: ;
			endcase
			return r;
		endfunction

		function void note_rect(in_word_t w);
			expected_words.push_back(predict_addresses(w));
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				mismatches++;
				$error("%s expected %h actual %h", name, want, got);
			end
		endfunction

		function void check_result(out_word_t got);
			out_word_t want;
			if (expected_words.size() == 0) begin
				mismatches++;
				$error("result word with nothing expected");
				return;
			end
			want = expected_words.pop_front();
			cmp_field("ok", want.ok, got.ok);
			cmp_field("y_address", want.y_address, got.y_address);
			cmp_field("u_address", want.u_address, got.u_address);
			cmp_field("v_address", want.v_address, got.v_address);
			cmp_field("dest_address", want.dest_address, got.dest_address);
			cmp_field("crop_width", want.crop_width, got.crop_width);
			cmp_field("crop_height", want.crop_height, got.crop_height);
			cmp_field("out_width", want.out_width, got.out_width);
			cmp_field("out_height", want.out_height, got.out_height);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [31:0] wr_data;
	logic        start;
	logic        busy;
	in_word_t    rect_word;
	logic        done;
	out_word_t   result;

	rect_addr_scoreboard sb;
	int                  cycle_count;

	yuv420_clip_rect_address_gen_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.start     (start),
		.busy      (busy),
		.rect_word (rect_word),
		.done      (done),
		.result    (result)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog on the whole run
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// monitor: everything is read in the active region of the edge, so it sees
	// the values that the block itself samples at that edge
	always @(posedge clk) begin
		if (arst_n) begin
			// register writes only happen while no word is in flight
			if (wr_en)
				sb.write_reg(wr_index, wr_data);
			// a word is taken when start is high and busy is low
			if (start && !busy)
				sb.note_rect(rect_word);
			// done marks a result word for exactly one cycle
			if (done)
				sb.check_result(result);
		end
	end

	// fill the bits above a register's width with noise, the block must mask them
	function automatic logic [31:0] pad_reg(logic [31:0] field, int width, bit noisy);
		logic [31:0] noise;
		noise = $urandom;
		if (noisy && width < 32)
			return field | (noise << width);
		return field;
	endfunction

	// one register write per clock; wr_en stays high across a sequence
	task automatic write_cfg_reg(logic [2:0] idx, logic [31:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
	endtask

	task automatic apply_settings(cfg_t c, bit noisy);
		write_cfg_reg(REG_FRAME_BASE, c.frame_base_addr);
		write_cfg_reg(REG_FORMAT,     pad_reg({30'd0, c.format_mode}, 2, noisy));
		write_cfg_reg(REG_FRAME_W,    pad_reg({20'd0, c.src_width}, 12, noisy));
		write_cfg_reg(REG_FRAME_H,    pad_reg({20'd0, c.src_height}, 12, noisy));
		write_cfg_reg(REG_DEST_BASE,  c.dest_base_addr);
		write_cfg_reg(REG_DEST_PITCH, pad_reg({17'd0, c.dest_pitch}, 15, noisy));
		write_cfg_reg(REG_SCALE_X,    pad_reg({16'd0, c.scale_x}, 16, noisy));
		write_cfg_reg(REG_SCALE_Y,    pad_reg({16'd0, c.scale_y}, 16, noisy));
		wr_en <= 1'b0;
	endtask

	// present one word and hold it until the block takes it
	task automatic send_rect(in_word_t w);
		start     <= 1'b1;
		rect_word <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// sender gap, the word lines carry noise meanwhile
	task automatic idle_cycles(int n);
		start     <= 1'b0;
		rect_word <= {$urandom, $urandom, $urandom};
		repeat (n) @(posedge clk);
	endtask

	// wait until every expected word has come back, then let the pipe settle
	task automatic drain();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_extreme();
		case ($urandom_range(0, 4))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h0000;
			3:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_word_t rand_rect();
		in_word_t w;
		int       sel, l, t;
		sel = $urandom_range(0, 99);
		if (sel < 25) begin
			// raw noise over every bit
			w = {$urandom, $urandom, $urandom};
		end else if (sel < 65) begin
			// well-formed rectangle starting inside a typical frame, box at or above and left of it
			l = $urandom_range(0, 1919);
			t = $urandom_range(0, 1079);
			w.rect_left   = 16'(l);
			w.rect_top    = 16'(t);
			w.rect_right  = 16'(l + $urandom_range(0, 640));
			w.rect_bottom = 16'(t + $urandom_range(0, 480));
			w.box_left    = 16'($urandom_range(0, l));
			w.box_top     = 16'($urandom_range(0, t));
		end else if (sel < 80) begin
			// negative screen coordinates
			l = -$urandom_range(0, 4000);
			t = -$urandom_range(0, 4000);
			w.rect_left   = 16'(l);
			w.rect_top    = 16'(t);
			w.rect_right  = 16'(l + $urandom_range(0, 3000));
			w.rect_bottom = 16'(t + $urandom_range(0, 3000));
			w.box_left    = 16'(l - $urandom_range(0, 2000));
			w.box_top     = 16'(t + $urandom_range(0, 2000));
		end else begin
			w.rect_left   = pick_extreme();
			w.rect_top    = pick_extreme();
			w.rect_right  = pick_extreme();
			w.rect_bottom = pick_extreme();
			w.box_left    = pick_extreme();
			w.box_top     = pick_extreme();
		end
		return w;
	endfunction

	function automatic in_word_t directed_rect(int k);
		in_word_t w;
		w = '0;
		case (k)
			0: ; // all zero
			1: w = {16'sd10, 16'sd20, 16'sd110, 16'sd70, 16'sd0, 16'sd0};
			// right left of left, bottom above top: sizes come from absolute values
			2: w = {16'sd300, 16'sd200, 16'sd100, 16'sd50, 16'sd40, 16'sd30};
			// negative coordinates wrap into the destination address
			3: w = {-16'sd5, -16'sd7, 16'sd3, 16'sd4, -16'sd100, -16'sd50};
			// widest spans, crop origin overflows 16 bits when scaled up
			4: w = {16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
			5: w = {16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
			// box right of and below the rectangle
			6: w = {16'sd0, 16'sd0, 16'sd64, 16'sd32, 16'h7FFF, 16'h7FFF};
			// odd origin for chroma halving
			default: w = {16'sd13, 16'sd9, 16'sd50, 16'sd41, 16'sd0, 16'sd0};
		endcase
		return w;
	endfunction

	function automatic cfg_t rand_settings();
		cfg_t c;
		int   sel;
		c.frame_base_addr = $urandom;
		c.dest_base_addr  = $urandom;
		sel = $urandom_range(0, 9);
		c.format_mode  = (sel < 4) ? FMT_YV12 : (sel < 8) ? FMT_I420 :
			(sel == 8) ? FMT_SPARE_2 : FMT_SPARE_3;
		c.src_width  = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(16, 1920));
		c.src_height = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(16, 1080));
		c.dest_pitch   = 15'($urandom);
		case ($urandom_range(0, 3))
			0:       c.scale_x = SCALE_ONE;
			1:       c.scale_x = SCALE_ONE >> 1;
			2:       c.scale_x = SCALE_ONE << 1;
			default: c.scale_x = 16'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0:       c.scale_y = SCALE_ONE;
			1:       c.scale_y = SCALE_ONE >> 1;
			2:       c.scale_y = SCALE_ONE << 1;
			default: c.scale_y = 16'($urandom);
		endcase
		return c;
	endfunction

	// bursts of random length with random gaps; gap_max 0 means back to back
	task automatic run_random(int total, int gap_max);
		int sent, burst, gap;
		sent = 0;
		while (sent < total) begin
			burst = $urandom_range(1, 16);
			while (burst > 0 && sent < total) begin
				send_rect(rand_rect());
				sent++;
				burst--;
			end
			gap = $urandom_range(0, gap_max);
			if (gap > 0)
				idle_cycles(gap);
		end
	endtask

	task automatic run_directed();
		for (int k = 0; k < DIRECTED_NUM; k++)
			send_rect(directed_rect(k));
	endtask

	initial begin
		cfg_t c;
		sb        = new();
		arst_n    = 1'b0;
		wr_en     = 1'b0;
		wr_index  = '0;
		wr_data   = '0;
		start     = 1'b0;
		rect_word = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: YV12, zero frame, scale 1.0
		run_random(10, 3);
		drain();

		// directed words on a typical YV12 frame
		c.frame_base_addr = 32'h1000_0000;
		c.format_mode     = FMT_YV12;
		c.src_width       = 12'd640;
		c.src_height      = 12'd480;
		c.dest_base_addr  = 32'h2000_0000;
		c.dest_pitch      = 15'd1280;
		c.scale_x         = SCALE_ONE;
		c.scale_y         = SCALE_ONE;
		apply_settings(c, 1'b0);
		run_directed();
		drain();

		// same words in I420 order, with noise above the register widths
		c.format_mode = FMT_I420;
		apply_settings(c, 1'b1);
		run_directed();
		drain();

		// largest frame and scale, so the crop origin overflows 16 bits
		c.src_width    = 12'hFFF;
		c.src_height   = 12'hFFF;
		c.dest_pitch   = 15'h7FFF;
		c.scale_x      = 16'hFFFF;
		c.scale_y      = 16'hFFFF;
		apply_settings(c, 1'b0);
		run_directed();
		drain();

		// every register at its top value, format code 3 unsupported
		apply_settings('1, 1'b0);
		run_random(15, 2);
		drain();

		// every register zero, scale 0
		apply_settings('0, 1'b0);
		run_random(15, 2);
		drain();

		// format code 2 unsupported, other fields still computed
		c = rand_settings();
		c.format_mode = FMT_SPARE_2;
		apply_settings(c, 1'b1);
		run_random(15, 4);
		drain();

		// random settings, some phases with no sender gaps at all
		for (int p = 0; p < 7; p++) begin
			apply_settings(rand_settings(), 1'($urandom_range(0, 1)));
			run_random(45, (p % 3 == 0) ? 0 : $urandom_range(2, 10));
			drain();
		end

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
